### src/cbor_item_decoder_core_assert.svh
// Assertion macros for the CBOR item decoder.
// No dependencies; included inside module bodies.
`ifndef CBOR_ITEM_DECODER_CORE_ASSERT_SVH
`define CBOR_ITEM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CBOR_DEC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define CBOR_DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define CBOR_DEC_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBOR_DEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/cbor_dec_pkg.sv
// Shared types and constants for the CBOR item decoder.
// No dependencies.
package cbor_dec_pkg;

  typedef enum logic [3:0] {
    K_UINT   = 4'd0,
    K_NEGINT = 4'd1,
    K_TEXT   = 4'd2,
    K_ARRAY  = 4'd3,
    K_MAP    = 4'd4,
    K_BOOL   = 4'd5,
    K_NULL   = 4'd6,
    K_FLOAT  = 4'd7,
    K_END    = 4'd8,
    K_TBYTE  = 4'd9,
    K_ERROR  = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_TRUNCATED = 3'd1,
    E_BAD_AI    = 3'd2,
    E_BAD_SIMPLE = 3'd3,
    E_BAD_MAJOR = 3'd4
  } err_t;

  localparam logic [2:0] MAJ_UINT   = 3'd0;
  localparam logic [2:0] MAJ_NEGINT = 3'd1;
  localparam logic [2:0] MAJ_BYTES  = 3'd2;
  localparam logic [2:0] MAJ_TEXT   = 3'd3;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_TAG    = 3'd6;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  localparam logic [4:0] AI_FALSE      = 5'd20;
  localparam logic [4:0] AI_TRUE       = 5'd21;
  localparam logic [4:0] AI_NULL       = 5'd22;
  localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
  localparam logic [4:0] AI_FLOAT32    = 5'd26;
  localparam logic [4:0] AI_FLOAT64    = 5'd27;

endpackage

### src/cbor_dec_byte_if.sv
// Input channel of the CBOR item decoder: stream bytes and end events.
// No dependencies.
interface cbor_dec_byte_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source(output valid, op, data_byte, input ready);
  modport sink(input valid, op, data_byte, output ready);
endinterface

### src/cbor_dec_token_if.sv
// Output channel of the CBOR item decoder: decoded tokens, at most one per input byte or end event.
// Depends on cbor_dec_pkg.
interface cbor_dec_token_if;
  import cbor_dec_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [63:0] value;
  err_t        error_code;
  logic        last_text_byte;

  modport source(output valid, kind, value, error_code, last_text_byte, input ready);
  modport sink(input valid, kind, value, error_code, last_text_byte, output ready);
endinterface

### src/cbor_dec_widen.sv
// Float32 to float64 bit widening, including subnormals, infinity and NaN.
// Combinational; no dependencies.
module cbor_dec_widen (
  input  logic [31:0] sng,
  output logic [63:0] dbl
);
  localparam logic [10:0] NORM_BIAS = 11'd896;
  localparam logic [10:0] SUB_BIAS  = 11'd874;

  logic        sgn;
  logic [7:0]  exp_s;
  logic [22:0] man;
  logic [4:0]  top;
  logic [4:0]  sh;
  logic [22:0] frac;

  assign sgn   = sng[31];
  assign exp_s = sng[30:23];
  assign man   = sng[22:0];

  // position of the leading one of a subnormal mantissa
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (man[i]) begin
        top = 5'(i);
      end
    end
  end

  assign sh   = 5'd23 - top;
  assign frac = man << sh;

  always_comb begin
    if (exp_s == 8'hFF) begin
      dbl = {sgn, 11'h7FF, man[22] | (|man), man[21:0], 29'b0};
    end else if (exp_s == 8'h00) begin
      if (man == 23'd0) begin
        dbl = {sgn, 63'b0};
      end else begin
        dbl = {sgn, 11'(top) + SUB_BIAS, frac, 29'b0};
      end
    end else begin
      dbl = {sgn, {3'b0, exp_s} + NORM_BIAS, man, 29'b0};
    end
  end
endmodule

### src/cbor_item_decoder_core.sv
// CBOR item decoder top level: byte register, header state, token register.
// Depends on cbor_dec_pkg, cbor_dec_byte_if, cbor_dec_token_if, cbor_dec_widen.
//
//   channel  dir  payload
//   bytes    in   op, data_byte
//   tokens   out  kind, value, error_code, last_text_byte
//
// One byte per cycle sustained while tokens are taken; a taken byte goes
// to the byte register, then is decoded into the token register.
// rst is synchronous: clears valid flags and all header state.
// A stalled token holds its register; the byte register keeps filling
// until both stages are full, then bytes.ready drops.
module cbor_item_decoder_core (
  input  logic                    clk,
  input  logic                    rst,
  cbor_dec_byte_if.sink           bytes,
  cbor_dec_token_if.source        tokens
);
  import cbor_dec_pkg::*;

  `include "cbor_item_decoder_core_assert.svh"

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ARG   = 4'b0010,
    PH_TEXT  = 4'b0100,
    PH_FAULT = 4'b1000
  } phase_t;

  // byte register
  logic        q_valid;
  logic        q_op;
  logic [7:0]  q_byte;

  // header state
  phase_t      phase, phase_next;
  logic [2:0]  pending_major, pending_major_next;
  logic [3:0]  arg_left, arg_left_next;
  logic [63:0] acc, acc_next;
  logic [63:0] text_left, text_left_next;
  logic        float_single, float_single_next;

  // token register
  logic        out_valid;
  kind_t       out_kind;
  logic [63:0] out_value;
  err_t        out_err;
  logic        out_last;

  logic        out_free;
  logic        adv;

  logic        has_res;
  kind_t       r_kind;
  logic [63:0] r_value;
  err_t        r_err;
  logic        r_last;

  logic [2:0]  major;
  logic [4:0]  ai;
  logic [63:0] acc_sh;
  logic [3:0]  arg_dec;
  logic [63:0] text_dec;
  logic        do_finish;
  logic [63:0] fin_arg;
  logic [2:0]  fin_major;
  logic        fin_single;
  logic [63:0] widened;

  assign out_free    = !out_valid || tokens.ready;
  assign adv         = q_valid && out_free;
  assign bytes.ready = !q_valid || adv;

  assign major    = q_byte[7:5];
  assign ai       = q_byte[4:0];
  assign acc_sh   = {acc[55:0], q_byte};
  assign arg_dec  = arg_left - 4'd1;
  assign text_dec = text_left - 64'd1;

  assign fin_arg    = (phase == PH_ARG) ? acc_sh : {59'b0, ai};
  assign fin_major  = (phase == PH_ARG) ? pending_major : major;
  assign fin_single = (phase == PH_ARG) ? float_single : 1'b0;

  cbor_dec_widen u_widen (
    .sng (fin_arg[31:0]),
    .dbl (widened)
  );

  always_comb begin
    phase_next         = phase;
    pending_major_next = pending_major;
    arg_left_next      = arg_left;
    acc_next           = acc;
    text_left_next     = text_left;
    float_single_next  = float_single;
    has_res            = 1'b0;
    r_kind             = K_END;
    r_value            = 64'd0;
    r_err              = E_NONE;
    r_last             = 1'b0;
    do_finish          = 1'b0;

    if (q_op) begin
      phase_next         = PH_IDLE;
      pending_major_next = 3'd0;
      arg_left_next      = 4'd0;
      acc_next           = 64'd0;
      text_left_next     = 64'd0;
      float_single_next  = 1'b0;
      has_res            = 1'b1;
      if (phase == PH_ARG || phase == PH_TEXT) begin
        r_kind = K_ERROR;
        r_err  = E_TRUNCATED;
      end
    end else begin
      case (phase)
        PH_ARG: begin
          acc_next      = acc_sh;
          arg_left_next = arg_dec;
          do_finish     = (arg_dec == 4'd0);
        end
        PH_TEXT: begin
          text_left_next = text_dec;
          has_res        = 1'b1;
          r_kind         = K_TBYTE;
          r_value        = {56'b0, q_byte};
          if (text_dec == 64'd0) begin
            r_last     = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_IDLE: begin
          pending_major_next = major;
          float_single_next  = 1'b0;
          if (major inside {MAJ_BYTES, MAJ_TAG}) begin
            has_res    = 1'b1;
            r_kind     = K_ERROR;
            r_err      = E_BAD_MAJOR;
            phase_next = PH_FAULT;
          end else if (major == MAJ_SIMPLE) begin
            case (ai)
              AI_FALSE, AI_TRUE: begin
                has_res = 1'b1;
                r_kind  = K_BOOL;
                r_value = {63'b0, ai == AI_TRUE};
              end
              AI_NULL: begin
                has_res = 1'b1;
                r_kind  = K_NULL;
              end
              AI_FLOAT32, AI_FLOAT64: begin
                float_single_next = (ai == AI_FLOAT32);
                acc_next          = 64'd0;
                arg_left_next     = 4'b0001 << ai[1:0];
                phase_next        = PH_ARG;
              end
              default: begin
                has_res    = 1'b1;
                r_kind     = K_ERROR;
                r_err      = E_BAD_SIMPLE;
                phase_next = PH_FAULT;
              end
            endcase
          end else if (ai > AI_FLOAT64) begin
            has_res    = 1'b1;
            r_kind     = K_ERROR;
            r_err      = E_BAD_AI;
            phase_next = PH_FAULT;
          end else if (ai <= AI_DIRECT_MAX) begin
            acc_next  = fin_arg;
            do_finish = 1'b1;
          end else begin
            acc_next      = 64'd0;
            arg_left_next = 4'b0001 << ai[1:0];
            phase_next    = PH_ARG;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_finish) begin
      phase_next = PH_IDLE;
      has_res    = 1'b1;
      r_value    = fin_arg;
      case (fin_major)
        MAJ_UINT:   r_kind = K_UINT;
        MAJ_NEGINT: begin
          r_kind  = K_NEGINT;
          r_value = ~fin_arg;
        end
        MAJ_TEXT: begin
          r_kind = K_TEXT;
          if (fin_arg != 64'd0) begin
            phase_next     = PH_TEXT;
            text_left_next = fin_arg;
          end
        end
        MAJ_ARRAY:  r_kind = K_ARRAY;
        MAJ_MAP:    r_kind = K_MAP;
        default: begin
          r_kind = K_FLOAT;
          if (fin_single) begin
            r_value = widened;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid       <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_IDLE;
      pending_major <= 3'd0;
      arg_left      <= 4'd0;
      acc           <= 64'd0;
      text_left     <= 64'd0;
      float_single  <= 1'b0;
    end else begin
      if (bytes.ready) begin
        q_valid <= bytes.valid;
      end
      if (adv) begin
        out_valid     <= has_res;
        phase         <= phase_next;
        pending_major <= pending_major_next;
        arg_left      <= arg_left_next;
        acc           <= acc_next;
        text_left     <= text_left_next;
        float_single  <= float_single_next;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready) begin
      q_op   <= bytes.op;
      q_byte <= bytes.data_byte;
    end
    if (adv) begin
      out_kind  <= r_kind;
      out_value <= r_value;
      out_err   <= r_err;
      out_last  <= r_last;
    end
  end

  assign tokens.valid          = out_valid;
  assign tokens.kind           = out_kind;
  assign tokens.value          = out_value;
  assign tokens.error_code     = out_err;
  assign tokens.last_text_byte = out_last;

  `CBOR_DEC_ASSERT_NEXT(a_fault_silent, clk, rst, adv && phase == PH_FAULT && !q_op, !out_valid)
  `CBOR_DEC_ASSERT_SAME(a_arg_left_live, clk, rst, phase == PH_ARG, arg_left != 4'd0)
  `CBOR_DEC_ASSERT_SAME(a_text_left_live, clk, rst, phase == PH_TEXT, text_left != 64'd0)
  `CBOR_DEC_ASSERT_SAME(a_last_is_tbyte, clk, rst, out_valid && out_last, out_kind == K_TBYTE)
  `CBOR_DEC_ASSERT_NEXT(a_end_clears, clk, rst, adv && q_op, phase == PH_IDLE && acc == 64'd0)
endmodule
